// ----- rtl/core/urcp_pkg.sv -----
// ----------------------------------------------------------------------------
// urcp_pkg
// Shared types, byte codes and decode helpers for the remote command parser.
// ----------------------------------------------------------------------------
package urcp_pkg;

  localparam int ACC_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CALC_WIDTH  = (ACC_WIDTH > VALUE_WIDTH) ? ACC_WIDTH : VALUE_WIDTH;

  localparam logic [7:0] BYTE_OPEN    = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE   = 8'h7D;
  localparam logic [7:0] BYTE_SEND    = 8'h50;
  localparam logic [7:0] BYTE_NOPARAM = 8'h23;
  localparam logic [7:0] BYTE_LED     = 8'h58;
  localparam logic [7:0] BYTE_HOLD    = 8'd10;
  localparam logic [7:0] BYTE_LETTER  = 8'h40;
  localparam logic [7:0] BYTE_FWD_HI  = 8'h41;
  localparam logic [7:0] BYTE_LEFT_HI = 8'h48;
  localparam logic [7:0] ASCII_ZERO   = 8'd48;

  localparam logic [7:0] CMD_0 = 8'h30;
  localparam logic [7:0] CMD_1 = 8'h31;
  localparam logic [7:0] CMD_2 = 8'h32;
  localparam logic [7:0] CMD_3 = 8'h33;

  localparam logic [7:0] OFFSET_0 = 8'd200;
  localparam logic [7:0] OFFSET_1 = 8'd19;
  localparam logic [7:0] OFFSET_2 = 8'd50;
  localparam logic [7:0] OFFSET_3 = 8'd10;

  localparam logic [2:0] POS_CMD    = 3'd1;
  localparam logic [2:0] POS_FOURTH = 3'd3;
  localparam logic [2:0] POS_MAX    = 3'd4;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_LEFT  = 3'd4
  } dir_t;

  function automatic dir_t dir_of_code(input logic [7:0] code);
    dir_t d;
    d = DIR_STOP;
    if (code == 8'h01) d = DIR_FWD;
    else if (code == 8'h05) d = DIR_BACK;
    else if (code >= 8'h02 && code <= 8'h04) d = DIR_RIGHT;
    else if (code >= 8'h06 && code <= 8'h08) d = DIR_LEFT;
    return d;
  endfunction

endpackage

// ----- rtl/core/uart_remote_command_parser.sv -----
// ----------------------------------------------------------------------------
// uart_remote_command_parser
// Byte-wise decoder of drive, LED and brace-framed parameter commands.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle and its result appears in the output
// register on the next cycle; a byte may be taken while the previous result
// is still being transferred out, as long as that result leaves in the same
// cycle. The per-byte decode and the times-ten accumulate of the frame
// value are both done between the input port and the result register.
module uart_remote_command_parser
  import urcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         direction,
  output logic               led_state,
  output logic               param_valid,
  output logic signed [31:0] param_value,
  output logic               send_request
);

  logic                 capturing, capturing_next;
  logic [2:0]           frame_pos, frame_pos_next;
  logic [7:0]           command_byte, command_byte_next;
  logic [7:0]           fourth_byte, fourth_byte_next;
  logic [ACC_WIDTH-1:0] accumulator, accumulator_next;
  dir_t                 drive_dir, drive_dir_next;
  logic                 led_level, led_level_next;

  logic                          res_valid;
  logic                          res_send;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic                          cmd_hit;
  logic [7:0]                    cmd_offset;
  logic signed [CALC_WIDTH-1:0]  acc_ext;
  logic                          capt_now;
  logic                          accept;

  dir_t                          out_dir;
  logic                          out_led;
  logic                          out_pvalid;
  logic signed [VALUE_WIDTH-1:0] out_pvalue;
  logic                          out_send;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (command_byte)
      CMD_0:   begin cmd_hit = 1'b1; cmd_offset = OFFSET_0; end
      CMD_1:   begin cmd_hit = 1'b1; cmd_offset = OFFSET_1; end
      CMD_2:   begin cmd_hit = 1'b1; cmd_offset = OFFSET_2; end
      CMD_3:   begin cmd_hit = 1'b1; cmd_offset = OFFSET_3; end
      default: begin cmd_hit = 1'b0; cmd_offset = 8'd0; end
    endcase
  end

  assign acc_ext = CALC_WIDTH'(signed'(accumulator));

  always_comb begin
    led_level_next    = led_level ^ (rx_byte == BYTE_LED);
    drive_dir_next    = drive_dir;
    capturing_next    = capturing;
    frame_pos_next    = frame_pos;
    command_byte_next = command_byte;
    fourth_byte_next  = fourth_byte;
    accumulator_next  = accumulator;
    res_valid         = 1'b0;
    res_send          = 1'b0;
    res_value         = '0;

    if (rx_byte > BYTE_HOLD) begin
      if (rx_byte >= BYTE_FWD_HI && rx_byte <= BYTE_LEFT_HI) begin
        drive_dir_next = dir_of_code(rx_byte - BYTE_LETTER);
      end else begin
        drive_dir_next = DIR_STOP;
      end
    end else if (rx_byte < BYTE_HOLD) begin
      drive_dir_next = dir_of_code(rx_byte);
    end

    capt_now = capturing || (rx_byte == BYTE_OPEN);

    if (rx_byte == BYTE_CLOSE) begin
      if (fourth_byte == BYTE_SEND) begin
        res_send = 1'b1;
      end else if (command_byte != BYTE_NOPARAM && cmd_hit) begin
        res_valid = 1'b1;
        res_value = VALUE_WIDTH'(acc_ext - CALC_WIDTH'(cmd_offset));
      end
      capturing_next    = 1'b0;
      frame_pos_next    = '0;
      command_byte_next = '0;
      fourth_byte_next  = '0;
      accumulator_next  = '0;
    end else if (capt_now) begin
      capturing_next = 1'b1;
      if (frame_pos == POS_CMD)    command_byte_next = rx_byte;
      if (frame_pos == POS_FOURTH) fourth_byte_next  = rx_byte;
      if (frame_pos >= POS_FOURTH) begin
        accumulator_next = (accumulator << 3) + (accumulator << 1)
                         + ACC_WIDTH'(rx_byte) - ACC_WIDTH'(ASCII_ZERO);
      end
      if (frame_pos < POS_MAX) frame_pos_next = frame_pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing    <= 1'b0;
      frame_pos    <= '0;
      command_byte <= '0;
      fourth_byte  <= '0;
      accumulator  <= '0;
      drive_dir    <= DIR_STOP;
      led_level    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        capturing    <= capturing_next;
        frame_pos    <= frame_pos_next;
        command_byte <= command_byte_next;
        fourth_byte  <= fourth_byte_next;
        accumulator  <= accumulator_next;
        drive_dir    <= drive_dir_next;
        led_level    <= led_level_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_dir    <= drive_dir_next;
      out_led    <= led_level_next;
      out_pvalid <= res_valid;
      out_pvalue <= res_value;
      out_send   <= res_send;
    end
  end

  assign direction    = out_dir;
  assign led_state    = out_led;
  assign param_valid  = out_pvalid;
  assign param_value  = out_pvalue;
  assign send_request = out_send;

  // a parameter and a report request never come from the same byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(param_valid && send_request))
    else $error("param and send request together");

  // value is zero whenever no parameter is emitted
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !param_valid) |-> (param_value == '0))
    else $error("stray parameter value");

  // a closing brace always leaves the frame state cleared
  assert property (@(posedge clk) disable iff (rst)
    (accept && rx_byte == BYTE_CLOSE) |=>
      (!capturing && frame_pos == '0 && accumulator == '0))
    else $error("frame not cleared on close");

  // position never runs past its saturation point
  assert property (@(posedge clk) disable iff (rst)
    frame_pos <= POS_MAX)
    else $error("frame position overflow");

endmodule
